// ===== hdl/nlcs_pkg.sv =====
`default_nettype none
package nlcs_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = 10;
  localparam int UseW = 11;
  localparam int MaxWindow = 6;
  localparam int FracBits = 16;
  localparam int LogSteps = 4;
  localparam int StepW = 5;
  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0] CharNl = 8'h0A;
  localparam logic [7:0] CharBar = 8'h7C;

  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncChar = 2'd1;
  localparam logic [1:0] FuncClose = 2'd2;
  localparam logic [1:0] FuncClear = 2'd3;

  localparam logic [1:0] RegOrder = 2'd0;
  localparam logic [1:0] RegSigma = 2'd1;
  localparam logic [1:0] RegUse = 2'd2;

  typedef struct packed {
    logic        go;
    logic [15:0] x;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [20:0] res;
  } log_rsp_t;

  // byte mask for a window of k+1 characters, k clamped to MaxWindow-1
  function automatic logic [47:0] win_mask(input logic [2:0] k);
    logic [47:0] m;
    m = '0;
    for (int b = 0; b < MaxWindow; b++) begin
      if (b <= int'(k)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/nlcs_sq_cell.sv =====
`default_nettype none
// One squaring step of the log2 chain: m = m*m >> 30, halve if >= 2.0.
// The result bits travel with the mantissa, newest bit in the lsb.
module nlcs_sq_cell (
  input  wire logic                          clk,
  input  wire logic                          vin,
  input  wire logic [31:0]                   m_in,
  input  wire logic [nlcs_pkg::LogSteps-1:0] b_in,
  output logic                               vout,
  output logic [31:0]                        m_out,
  output logic [nlcs_pkg::LogSteps-1:0]      b_out
);
  import nlcs_pkg::*;
  logic [63:0] sq;
  logic [33:0] s30;
  assign sq = {32'd0, m_in} * {32'd0, m_in};
  assign s30 = sq[63:30];
  always_ff @(posedge clk) begin
    vout <= vin;
    if (s30 >= 34'h0_8000_0000) begin
      m_out <= s30[32:1];
      b_out <= {b_in[LogSteps-2:0], 1'b1};
    end else begin
      m_out <= s30[31:0];
      b_out <= {b_in[LogSteps-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/nlcs_log2.sv =====
`default_nettype none
// Fixed-point log2: a row of LogSteps squaring cells, recirculated
// FracBits/LogSteps times, one result bit per cell pass.
module nlcs_log2 (
  input  wire logic clk,
  input  wire logic rst,
  input  nlcs_pkg::log_req_t req,
  output nlcs_pkg::log_rsp_t rsp
);
  import nlcs_pkg::*;
  logic [31:0] m [0:LogSteps];
  logic        v [0:LogSteps];
  logic [LogSteps-1:0] b [0:LogSteps];
  logic [3:0]  n;
  logic [15:0] frac;
  logic [StepW-1:0] left;
  logic        busy;
  logic [31:0] m_start;
  logic [3:0]  n_calc;
  logic [15:0] xx;

  always_comb begin
    xx = (req.x == 16'd0) ? 16'd1 : req.x;
    n_calc = '0;
    for (int i = 1; i < 16; i++) if (xx[i]) n_calc = 4'(i);
    m_start = 32'({16'd0, xx} << (30 - int'(n_calc)));
  end

  // the last cell feeds the first directly; no relaunch after the final pass
  assign m[0] = busy ? m[LogSteps] : m_start;
  assign v[0] = req.go || (busy && v[LogSteps] && left != StepW'(1));
  assign b[0] = '0;

  genvar g;
  generate
    for (g = 0; g < LogSteps; g++) begin : g_cell
      nlcs_sq_cell u_cell (
        .clk(clk), .vin(v[g]), .m_in(m[g]), .b_in(b[g]),
        .vout(v[g+1]), .m_out(m[g+1]), .b_out(b[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (req.go) begin
      busy <= 1'b1;
      left <= StepW'(FracBits / LogSteps);
      n <= n_calc;
      frac <= '0;
    end else if (busy && v[LogSteps]) begin
      frac <= {frac[15-LogSteps:0], b[LogSteps]};
      left <= left - 1'b1;
      if (left == StepW'(1)) busy <= 1'b0;
    end
  end

  // rising edge of !busy after a run marks completion
  logic busy_d;
  always_ff @(posedge clk) begin
    if (rst) busy_d <= 1'b0;
    else busy_d <= busy;
  end
  assign rsp.done = busy_d && !busy;
  assign rsp.res = {1'b0, n, frac};
endmodule
`default_nettype wire

// ===== hdl/nlcs_table.sv =====
`default_nettype none
// Context table: a memory scanned one entry a cycle for the first match.
module nlcs_table (
  input  wire logic        clk,
  input  wire logic        wr,
  input  wire logic [9:0]  wr_idx,
  input  wire logic [47:0] wr_ctx,
  input  wire logic [15:0] wr_prob,
  input  wire logic        rd,
  input  wire logic [9:0]  rd_idx,
  output logic [47:0]      rd_ctx,
  output logic [15:0]      rd_prob
);
  import nlcs_pkg::*;
  logic [47:0] ctx_mem [0:TableDepth-1];
  logic [15:0] prob_mem [0:TableDepth-1];
  always_ff @(posedge clk) begin
    if (wr) begin
      ctx_mem[wr_idx] <= wr_ctx;
      prob_mem[wr_idx] <= wr_prob;
    end
    if (rd) begin
      rd_ctx <= ctx_mem[rd_idx];
      rd_prob <= prob_mem[rd_idx];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ngram_language_cost_scorer.sv =====
`default_nettype none
// N-gram language cost scorer.
// Items enter on start (taken when busy is low) with func selecting load
// entry, text character, close model or clear best. Every item yields one
// result on the result ports for one cycle, flagged by done; the receiver
// cannot hold it off. Registers (order, alphabet size, entries in use) are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data while idle.
// Load, close and clear go straight to the output state. A text character
// that fills the window scans the entries in use one entry a cycle, stopping
// early on a hit, drains the outstanding read, then runs log2 through a row
// of four squaring cells recirculated four times and adds its cost to the
// running total. Characters that do not fill the window go straight to
// the output state.
// One item is in flight at a time. Reset clears window, total and best;
// the table contents stay undefined until loaded.
module ngram_language_cost_scorer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  entry_index,
  input  wire logic [47:0] entry_context,
  input  wire logic [15:0] entry_prob,
  input  wire logic [7:0]  text_char,
  input  wire logic [7:0]  model_id,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  output logic             done,
  output logic [47:0]      running_bits,
  output logic             scored,
  output logic             matched,
  output logic [47:0]      best_bits,
  output logic [7:0]       best_model,
  output logic             best_valid
);
  import nlcs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LOG, S_WAIT, S_ADD, S_OUT} state_t;
  state_t state;

  logic [2:0]  ctx_order;
  logic [8:0]  sigma;
  logic [10:0] use_cnt;
  logic [47:0] window;
  logic [2:0]  fill;
  logic [47:0] total;
  logic [47:0] wmask;
  logic [2:0]  k;
  logic [10:0] use_lim;
  logic [10:0] scan_i;
  logic        rd_v;
  logic [47:0] rd_ctx;
  logic [15:0] rd_prob;
  logic        hit;
  logic [15:0] hit_p;
  logic        zero_p;
  logic        tbl_rd;
  logic [7:0]  cch;
  log_req_t    lreq;
  log_rsp_t    lrsp;
  logic [47:0] cost;
  logic [48:0] sum;
  logic [3:0]  wnd;

  assign k = (ctx_order > 3'(MaxWindow - 1)) ? 3'(MaxWindow - 1) : ctx_order;
  assign wnd = {1'b0, k} + 4'd1;
  assign wmask = win_mask(k);
  assign use_lim = (use_cnt > 11'(TableDepth)) ? 11'(TableDepth) : use_cnt;
  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign cch = (text_char == CharNl) ? CharBar : text_char;
  assign tbl_rd = (state == S_SCAN) && (scan_i < use_lim) && !hit;
  assign sum = {1'b0, total} + {1'b0, cost};

  nlcs_table u_table (
    .clk(clk), .wr(start && !busy && func == FuncLoad), .wr_idx(entry_index),
    .wr_ctx(entry_context), .wr_prob(entry_prob),
    .rd(tbl_rd), .rd_idx(scan_i[IdxW-1:0]), .rd_ctx(rd_ctx), .rd_prob(rd_prob)
  );

  nlcs_log2 u_log (.clk(clk), .rst(rst), .req(lreq), .rsp(lrsp));

  always_comb begin
    lreq.go = 1'b0;
    lreq.x = hit ? hit_p : ((sigma == 9'd0) ? 16'd1 : 16'(sigma));
    if (state == S_LOG) lreq.go = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx_order <= 3'd3;
      sigma <= 9'd256;
      use_cnt <= '0;
      window <= '0;
      fill <= '0;
      total <= '0;
      best_bits <= Mask48;
      best_model <= '0;
      best_valid <= 1'b0;
      done <= 1'b0;
      rd_v <= 1'b0;
      hit <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegOrder: ctx_order <= cfg_data[2:0];
          RegSigma: sigma <= cfg_data[8:0];
          RegUse:   use_cnt <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (start) begin
          scored <= 1'b0;
          matched <= 1'b0;
          case (func)
            FuncChar: begin
              if ({1'b0, fill} >= wnd) begin
                window <= ((window >> 8) | (48'(cch) << (8 * k))) & wmask;
                state <= S_SCAN;
              end else begin
                window <= (window | (48'(cch) << (8 * fill))) & wmask;
                fill <= fill + 1'b1;
                state <= ({1'b0, fill} + 4'd1 >= wnd) ? S_SCAN : S_OUT;
              end
              scan_i <= '0;
              rd_v <= 1'b0;
              hit <= 1'b0;
            end
            FuncClose: begin
              if (!best_valid || total < best_bits) begin
                best_bits <= total;
                best_model <= model_id;
              end
              best_valid <= 1'b1;
              window <= '0;
              fill <= '0;
              total <= '0;
              state <= S_OUT;
            end
            FuncClear: begin
              best_bits <= Mask48;
              best_model <= '0;
              best_valid <= 1'b0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SCAN: begin
          rd_v <= tbl_rd;
          if (tbl_rd) scan_i <= scan_i + 1'b1;
          // the read issued alongside a hit is dropped, so keep the hit's prob
          if (rd_v && !hit && ((rd_ctx & wmask) == window)) begin
            hit <= 1'b1;
            hit_p <= rd_prob;
            zero_p <= (rd_prob == 16'd0);
            state <= S_LOG;
          end else if (!tbl_rd && !rd_v) begin
            state <= S_LOG;
          end
        end
        S_LOG: state <= S_WAIT;
        S_WAIT: if (lrsp.done) begin
          if (hit && zero_p) cost <= Mask48;
          else if (hit) cost <= 48'((21'd16 << FracBits) - lrsp.res);
          else cost <= 48'(lrsp.res);
          state <= S_ADD;
        end
        S_ADD: begin
          total <= sum[48] ? Mask48 : sum[47:0];
          scored <= 1'b1;
          matched <= hit;
          state <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign running_bits = total;
endmodule
`default_nettype wire
